// File: hdl/tpc_pkg.sv
package tpc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 5;

  localparam logic [DataW-1:0] US_PER_MINUTE  = 32'd60000000;
  localparam logic [DataW-1:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] TIMEOUT_RESET  = 32'd500000;
  localparam logic [CntW-1:0]  LAST_BIT       = 5'd31;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_STOPPED   = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_READ = 1'b1
  } command_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/tpc_in_if.sv
interface tpc_in_if import tpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             command;
  logic [DataW-1:0] timestamp_us;

  modport source (output valid, command, timestamp_us, input ready);
  modport sink   (input valid, command, timestamp_us, output ready);
endinterface

// File: hdl/tpc_out_if.sv
interface tpc_out_if import tpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] rpm;
  logic [DataW-1:0] period_us;
  logic [1:0]       status;

  modport source (output valid, rpm, period_us, status, input ready);
  modport sink   (input valid, rpm, period_us, status, output ready);
endinterface

// File: hdl/tach_period_capture_rpm.sv
// Fan tachometer input capture with rpm conversion.
//
// item_i carries one word per event: command (edge seen / read rpm) and a
// free-running microsecond timestamp. result_o returns one word per read:
// rpm, the stored period and a status code. Edge words give no result.
// cfg_we_i / cfg_wdata_i write the stall timeout; write only while idle.
//
// Every edge word and every read without a fresh period runs a
// bit-serial subtract/compare of timestamp against the last edge time,
// one bit per cycle. A read with a fresh period runs the radix-2
// divider for 60e6 / period, one quotient bit a cycle, before the word
// goes to the output register. Periods of zero or all ones skip the
// divider.
// One word is in flight at a time; item_i.ready is high only when idle.
//
// The output register holds a finished word while result_o stalls; the
// block keeps accepting words meanwhile, and a later read waits in its
// last state until the register drains.
//
// Reset: timeout 500000 us, last edge time 0, period all ones, output empty.
module tach_period_capture_rpm import tpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  tpc_in_if.sink           item_i,
  tpc_out_if.source        result_o,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUB,
    S_DIV,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [DataW-1:0] timeout_q;
  logic [DataW-1:0] last_q;
  logic [DataW-1:0] period_q;
  logic             fresh_q;
  logic             cmd_q;
  logic [DataW-1:0] ts_q, ts_d;
  logic [DataW-1:0] diff_q, diff_d;
  logic             borrow_q, borrow_d;
  logic             gt_q, gt_d;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] res_rpm_q;
  status_e          res_status_q;
  logic             out_valid_q;
  logic [DataW-1:0] out_rpm_q;
  logic [DataW-1:0] out_period_q;
  status_e          out_status_q;

  logic             accept;
  logic             out_free;
  logic             div_start;
  logic [DataW-1:0] numerator;
  div_stat_t        div_stat;
  logic [DataW-1:0] div_quot;
  logic             a_bit, b_bit, d_bit, t_bit;

  assign accept   = item_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || result_o.ready;

  // Fresh read with an ordinary period goes to the divider.
  assign div_start = accept && (item_i.command == CMD_READ) && fresh_q &&
                     (period_q != '0) && (period_q != ALL_ONES);
  // Round to nearest: add half the divisor; the sum stays below 2^32.
  assign numerator = US_PER_MINUTE + {1'b0, period_q[DataW-1:1]};

  // Serial subtract ts - last, LSB first; compare against timeout as bits
  // go by: the highest differing bit decides.
  assign a_bit    = ts_q[0];
  assign b_bit    = last_q[cnt_q];
  assign t_bit    = timeout_q[cnt_q];
  assign d_bit    = a_bit ^ b_bit ^ borrow_q;
  assign borrow_d = (!a_bit && b_bit) || (!a_bit && borrow_q) || (b_bit && borrow_q);
  assign gt_d     = (d_bit != t_bit) ? d_bit : gt_q;
  assign diff_d   = {d_bit, diff_q[DataW-1:1]};
  assign ts_d     = {ts_q[0], ts_q[DataW-1:1]};

  tpc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .numerator_i (numerator),
    .divisor_i   (period_q),
    .stat_o      (div_stat),
    .quot_o      (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      timeout_q    <= TIMEOUT_RESET;
      last_q       <= '0;
      period_q     <= ALL_ONES;
      fresh_q      <= 1'b0;
      cmd_q        <= 1'b0;
      ts_q         <= '0;
      diff_q       <= '0;
      borrow_q     <= 1'b0;
      gt_q         <= 1'b0;
      cnt_q        <= '0;
      res_rpm_q    <= '0;
      res_status_q <= ST_NOT_READY;
      out_valid_q  <= 1'b0;
      out_rpm_q    <= '0;
      out_period_q <= '0;
      out_status_q <= ST_NOT_READY;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      // drain the output register when taken; emit reloads it on its own
      if (out_valid_q && result_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= item_i.command;
            if ((item_i.command == CMD_READ) && fresh_q) begin
              fresh_q      <= 1'b0;
              res_status_q <= ST_VALID;
              if (period_q == '0) begin
                res_rpm_q <= ALL_ONES;
                state_q   <= S_EMIT;
              end else if (period_q == ALL_ONES) begin
                res_rpm_q <= '0;
                state_q   <= S_EMIT;
              end else begin
                state_q <= S_DIV;
              end
            end else begin
              ts_q     <= item_i.timestamp_us;
              cnt_q    <= '0;
              borrow_q <= 1'b0;
              gt_q     <= 1'b0;
              state_q  <= S_SUB;
            end
          end
        end
        S_SUB: begin
          ts_q     <= ts_d;
          diff_q   <= diff_d;
          borrow_q <= borrow_d;
          gt_q     <= gt_d;
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == LAST_BIT) begin
            if (cmd_q == CMD_EDGE) begin
              // timestamp has rotated back to its original value
              period_q <= diff_d;
              last_q   <= ts_d;
              fresh_q  <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              res_rpm_q    <= '0;
              res_status_q <= gt_d ? ST_STOPPED : ST_NOT_READY;
              state_q      <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_rpm_q <= div_quot;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_rpm_q    <= res_rpm_q;
            out_period_q <= period_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign item_i.ready       = (state_q == S_IDLE);
  assign result_o.valid     = out_valid_q;
  assign result_o.rpm       = out_rpm_q;
  assign result_o.period_us = out_period_q;
  assign result_o.status    = out_status_q;

  a_edge_sets_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB && cnt_q == LAST_BIT && cmd_q == CMD_EDGE) |=> fresh_q)
    else $error("edge capture did not mark period fresh");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (period_q != '0 && !div_stat.busy))
    else $error("divider started with zero period or while busy");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output loaded outside emit");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_DIV))
    else $error("divider busy outside divide state");

endmodule

// File: hdl/tpc_div.sv
// Restoring radix-2 divider: one quotient bit per cycle, MSB first.
// Divisor must be nonzero at start.
module tpc_div import tpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] numerator_i,
  input  logic [DataW-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DataW-1:0] quot_o
);

  logic [DataW-1:0] num_q, num_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW:0]   trial;
  logic [DataW:0]   sub;
  logic             ge;

  assign trial = {rem_q, num_q[DataW-1]};
  assign sub   = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? sub[DataW-1:0] : trial[DataW-1:0];
  // quotient bits shift in where numerator bits shift out
  assign num_d = {num_q[DataW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        num_q  <= numerator_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_BIT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

  a_divisor_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && $past(busy_q)) |-> $stable(dvs_q))
    else $error("divisor changed mid-divide");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("done without a finished divide");

endmodule

// File: verif/tach_period_capture_rpm_tb.sv
`timescale 1ns / 1ps

module tach_period_capture_rpm_tb;
  import tpc_pkg::*;

  // One input word as the sender queues it.
  typedef struct packed {
    command_e         command;
    logic [DataW-1:0] ts;
  } tach_word_t;

  // One rpm reading as the block should return it.
  typedef struct packed {
    logic [DataW-1:0] rpm;
    logic [DataW-1:0] period_us;
    status_e          status;
  } tach_reading_t;

  // Receiver behavior; each one holds for a random stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  localparam int unsigned SettleCycles = 48;    // longest single-word latency plus margin
  localparam int unsigned StuckLimit   = 4000;  // cycles with work pending but no handshake
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned MaxShown     = 10;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [DataW-1:0] cfg_wdata   = '0;

  // Driver-owned copies of the channel inputs, all known from time zero.
  logic             word_valid   = 1'b0;
  logic             word_command = 1'b0;
  logic [DataW-1:0] word_ts      = '0;
  logic             result_ready = 1'b0;

  tpc_in_if  item_if ();
  tpc_out_if result_if ();

  assign item_if.valid        = word_valid;
  assign item_if.command      = word_command;
  assign item_if.timestamp_us = word_ts;
  assign result_if.ready      = result_ready;

  tach_period_capture_rpm u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 12 ns clock: low half first, then high half.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Words waiting for the driver, and readings waiting for the block.
  tach_word_t    pending_words[$];
  tach_reading_t expected_readings[$];

  // Shadow of the capture state, advanced on every accepted word.
  logic [DataW-1:0] stall_timeout_q = TIMEOUT_RESET;
  logic [DataW-1:0] last_edge_q     = '0;
  logic [DataW-1:0] edge_period_q   = ALL_ONES;
  logic             period_fresh_q  = 1'b0;

  // Bookkeeping for the summary and the verdict.
  int unsigned faults        = 0;
  int unsigned edges_taken   = 0;
  int unsigned reads_taken   = 0;
  int unsigned got_valid     = 0;
  int unsigned got_stopped   = 0;
  int unsigned got_not_ready = 0;
  int unsigned stuck_cycles  = 0;
  bit          word_taken    = 1'b0;

  // Rounded 60e6 / period, with the two saturating special cases.
  function automatic logic [DataW-1:0] rpm_of(input logic [DataW-1:0] p);
    logic [63:0] q;
    if (p == ALL_ONES) return '0;
    if (p == '0) return ALL_ONES;
    q = ({32'd0, US_PER_MINUTE} + {33'd0, p[DataW-1:1]}) / {32'd0, p};
    return q[DataW-1:0];
  endfunction

  // Advance the shadow state by one accepted word; a read queues a reading.
  task automatic track_word(input command_e cmd, input logic [DataW-1:0] ts);
    tach_reading_t r;
    logic [DataW-1:0] elapsed;
    if (cmd == CMD_EDGE) begin
      edge_period_q  = ts - last_edge_q;
      last_edge_q    = ts;
      period_fresh_q = 1'b1;
      edges_taken++;
    end else begin
      elapsed     = ts - last_edge_q;
      r.rpm       = '0;
      r.period_us = edge_period_q;
      if (period_fresh_q) begin
        period_fresh_q = 1'b0;
        r.rpm          = rpm_of(edge_period_q);
        r.status       = ST_VALID;
      end else if (elapsed > stall_timeout_q) begin
        r.status = ST_STOPPED;
      end else begin
        r.status = ST_NOT_READY;
      end
      expected_readings.push_back(r);
      reads_taken++;
    end
  endtask

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= MaxShown) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    tach_reading_t exp_r;
    if (rst_ni && word_valid && item_if.ready) begin
      word_taken = 1'b1;
      track_word(command_e'(word_command), word_ts);
    end
    if (rst_ni && result_if.valid && result_ready) begin
      if (expected_readings.size() == 0) begin
        note_fault($sformatf("reading with none pending: rpm %0d period %0d status %0d",
                             result_if.rpm, result_if.period_us, result_if.status));
      end else begin
        exp_r = expected_readings.pop_front();
        case (exp_r.status)
          ST_VALID:   got_valid++;
          ST_STOPPED: got_stopped++;
          default:    got_not_ready++;
        endcase
        if (result_if.rpm !== exp_r.rpm)
          note_fault($sformatf("rpm expected %0d got %0d", exp_r.rpm, result_if.rpm));
        if (result_if.period_us !== exp_r.period_us)
          note_fault($sformatf("period_us expected %0d got %0d",
                               exp_r.period_us, result_if.period_us));
        if (result_if.status !== exp_r.status)
          note_fault($sformatf("status expected %s got %0d",
                               exp_r.status.name(), result_if.status));
      end
    end
  end

  // Driver: hold a word until taken, then advance; send in bursts with gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    tach_word_t nxt;
    if (word_valid && !word_taken) begin
      // hold the current word until the block takes it
    end else if (gap_left != 0) begin
      word_valid <= 1'b0;
      gap_left--;
    end else if (pending_words.size() != 0) begin
      nxt = pending_words.pop_front();
      word_valid   <= 1'b1;
      word_command <= nxt.command;
      word_ts      <= nxt.ts;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 20);
        case ($urandom_range(0, 7))
          0, 1:    gap_left = 0;
          7:       gap_left = $urandom_range(13, 60);
          default: gap_left = $urandom_range(1, 12);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      word_valid <= 1'b0;
    end
    word_taken = 1'b0;
  end

  // Receiver: stall on a mode that is picked anew at random times.
  rx_mode_e    rx_mode    = RX_OPEN;
  logic [31:0] rx_pattern = 32'h1;
  int unsigned rx_left    = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      rx_pattern = $urandom | 32'h1;
      rx_left    = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 5) == 0);
      default: begin
        result_ready <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
      end
    endcase
  end

  // Watchdog: count cycles with work pending and no handshake on either side.
  always @(posedge clk_i) begin
    if ((word_valid && item_if.ready) || (result_if.valid && result_ready)) begin
      stuck_cycles <= 0;
    end else if (word_valid || pending_words.size() != 0 ||
                 expected_readings.size() != 0) begin
      stuck_cycles <= stuck_cycles + 1;
    end else begin
      stuck_cycles <= 0;
    end
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("[%0t] no handshake for %0d cycles", $realtime, StuckLimit);
    $display("tach_period_capture_rpm test failed");
    $finish;
  end

  // Stimulus helpers.
  int unsigned words_queued = 0;

  task automatic push_word(input command_e cmd, input logic [DataW-1:0] ts);
    tach_word_t w;
    w.command = cmd;
    w.ts      = ts;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Write the stall timeout at a falling edge; the block must be idle.
  task automatic write_timeout(input logic [DataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    stall_timeout_q = value;
  endtask

  // Drain every queued word and reading, then let a word with no
  // reading (an edge) finish its compare pass before going on.
  task automatic drain;
    while (pending_words.size() != 0 || word_valid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Edge-to-edge spacing: mostly a plausible fan, sometimes the extremes.
  function automatic logic [DataW-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1:       return ALL_ONES - $urandom_range(0, 2);
      6, 7:    return $urandom_range(1, 4000);
      8:       return $urandom_range(120000, 5000000);
      9:       return $urandom;
      default: return $urandom_range(4000, 120000);
    endcase
  endfunction

  // Corner cases under the reset timeout of 500000 us.
  task automatic queue_directed;
    logic [DataW-1:0] t;
    // reads before any edge measure from last edge time zero
    push_word(CMD_READ, 32'd0);             // elapsed zero: not ready
    push_word(CMD_READ, TIMEOUT_RESET);     // elapsed equal to timeout: not ready
    push_word(CMD_READ, TIMEOUT_RESET + 1); // just past timeout: stopped
    push_word(CMD_READ, ALL_ONES);          // far past timeout: stopped
    push_word(CMD_EDGE, 32'd0);             // zero period: saturated rpm
    push_word(CMD_READ, 32'd0);
    push_word(CMD_READ, 32'd10);            // nothing fresh: not ready
    push_word(CMD_EDGE, ALL_ONES);          // all-ones period: rpm 0, still valid
    push_word(CMD_READ, ALL_ONES);
    push_word(CMD_EDGE, 32'h10);            // wraps through zero: period 0x11
    push_word(CMD_READ, 32'h10);
    push_word(CMD_EDGE, 32'h11);            // period 1: largest real rpm
    push_word(CMD_READ, 32'h11);
    t = 32'h11 + 32'd40000000;              // 1.5 rpm rounds up to 2
    push_word(CMD_EDGE, t);
    push_word(CMD_READ, t);
    t += 32'd120000001;
    push_word(CMD_EDGE, t);                 // overwritten before the read
    t += 32'd120000000;
    push_word(CMD_EDGE, t);                 // only this period counts
    push_word(CMD_READ, t);
    t += 32'h8000_0000;                     // top bit of the period set
    push_word(CMD_EDGE, t);
    push_word(CMD_READ, t);
    t += 32'd2;
    push_word(CMD_EDGE, t);
    push_word(CMD_READ, t);
    push_word(CMD_READ, t + TIMEOUT_RESET + 1);
    push_word(CMD_READ, t + TIMEOUT_RESET);
  endtask

  // Mostly steady fan runs with reads in between, plus timeout probes,
  // long silences and raw noise.
  task automatic queue_random(input int unsigned count);
    logic [DataW-1:0] now;
    logic [DataW-1:0] period;
    int unsigned      stop_at;
    now     = $urandom;
    stop_at = words_queued + count;
    while (words_queued < stop_at) begin
      case ($urandom_range(0, 9))
        7: begin
          // probe the timeout boundary from the latest edge
          push_word(CMD_READ, now + stall_timeout_q);
          push_word(CMD_READ, now + stall_timeout_q + 1);
          push_word(CMD_READ, now - 1);
        end
        8: begin
          repeat ($urandom_range(1, 4))
            push_word(command_e'($urandom_range(0, 1)), $urandom);
        end
        9: begin
          // fan stops, is polled, then restarts much later
          push_word(CMD_READ, now + $urandom);
          now += $urandom;
          push_word(CMD_EDGE, now);
        end
        default: begin
          period = pick_period();
          repeat ($urandom_range(2, 8)) begin
            now += period + $urandom_range(0, period >> 5);
            push_word(CMD_EDGE, now);
            case ($urandom_range(0, 3))
              0: ;
              3: begin
                push_word(CMD_READ, now + $urandom_range(0, period));
                push_word(CMD_READ, now + $urandom_range(0, period));
              end
              default: push_word(CMD_READ, now + $urandom_range(0, period));
            endcase
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [DataW-1:0] timeouts [NumPhases];
    timeouts[0] = TIMEOUT_RESET;
    timeouts[1] = '0;
    timeouts[2] = ALL_ONES;
    timeouts[3] = $urandom_range(1, 3000000);
    timeouts[4] = 32'd1;
    timeouts[5] = $urandom;

    // hold reset, then release it on a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      write_timeout(timeouts[ph]);
      if (ph == 0) begin
        queue_directed();
        queue_random(120);
      end else begin
        queue_random(180);
      end
      drain();
    end

    $display("Covered %0d words (%0d edges, %0d reads) over %0d stall timeout settings.",
             edges_taken + reads_taken, edges_taken, reads_taken, NumPhases);
    $display("Readings checked: %0d valid, %0d stopped, %0d not ready; %0d mismatches.",
             got_valid, got_stopped, got_not_ready, faults);
    if (faults == 0) begin
      $display("tach_period_capture_rpm test passed");
    end else begin
      $display("tach_period_capture_rpm test failed");
    end
    $finish;
  end

endmodule
